// ===== hdl/positional_list_engine_macros.svh =====
// ----------------------------------------------------------------------------
// positional_list_engine_macros.svh
// Assertion macros used by the checker file of the list engine.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pl_pkg.sv =====
// ----------------------------------------------------------------------------
// pl_pkg
// Types and fixed constants of the positional list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pl_pkg;

    // Field widths of the request and response words
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Most response words one read-all request gives
    localparam int MAX_RESULTS = 16;

    // Request codes; code 7 is unused and acts as a no-op
    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_POS   = 3'd5,
        FN_READ_ALL  = 3'd6
    } t_func;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // take the request word and execute it
        logic rd_next;   // load the next read-all entry into the output
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
        logic rd_multi;  // request on the input is a read-all of two or more
        logic rd_last;   // next read-all entry is the final one
    } t_sts;

endpackage

// ===== hdl/pl_req_if.sv =====
// ----------------------------------------------------------------------------
// pl_req_if
// Request channel: valid/ready handshake with func, value and pos.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pl_req_if;
    logic                                valid;
    logic                                ready;
    logic [pl_pkg::FUNC_W-1:0]           func;
    logic signed [pl_pkg::VALUE_W-1:0]   value;
    logic [pl_pkg::POS_W-1:0]            pos;

    modport source (output valid, func, value, pos, input ready);
    modport sink   (input valid, func, value, pos, output ready);
endinterface

// ===== hdl/pl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pl_rsp_if
// Response channel: valid/ready handshake with status, count, element, last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [pl_pkg::STATUS_W-1:0]         status;
    logic [pl_pkg::COUNT_W-1:0]          count;
    logic signed [pl_pkg::VALUE_W-1:0]   element;
    logic                                last;

    modport source (output valid, status, count, element, last, input ready);
    modport sink   (input valid, status, count, element, last, output ready);
endinterface

// ===== hdl/pl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pl_ctrl
// Controller: accepts requests and sequences multi-word read-all responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  pl_pkg::t_sts  i_sts,
    output pl_pkg::t_cmd  o_cmd
);

    pl_pkg::t_state r_state;
    pl_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pl_pkg::S_IDLE: begin
                if (i_req_valid && i_sts.out_free && i_sts.rd_multi) begin
                    n_state = pl_pkg::S_READ;
                end
            end
            pl_pkg::S_READ: begin
                if (i_sts.out_free && i_sts.rd_last) begin
                    n_state = pl_pkg::S_IDLE;
                end
            end
            default: n_state = pl_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready    = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.rd_next  = 1'b0;
        unique case (r_state)
            pl_pkg::S_IDLE: begin
                o_req_ready  = i_sts.out_free;
                o_cmd.accept = i_req_valid && i_sts.out_free;
            end
            pl_pkg::S_READ: begin
                o_cmd.rd_next = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/pl_dp.sv =====
// ----------------------------------------------------------------------------
// pl_dp
// Datapath: row of list cells with parallel shift, entry count, read-all
// index and the response output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pl_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pl_pkg::t_cmd                        i_cmd,
    output pl_pkg::t_sts                        o_sts,
    input  logic [pl_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [pl_pkg::VALUE_W-1:0]   i_value,
    input  logic [pl_pkg::POS_W-1:0]            i_pos,
    input  logic                                i_rsp_ready,
    output logic                                o_rsp_valid,
    output logic [pl_pkg::STATUS_W-1:0]         o_status,
    output logic [pl_pkg::COUNT_W-1:0]          o_count,
    output logic signed [pl_pkg::VALUE_W-1:0]   o_element,
    output logic                                o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = ((CW > pl_pkg::POS_W) ? CW : pl_pkg::POS_W) + 1;

    // List cells and control registers
    logic signed [pl_pkg::VALUE_W-1:0] r_cells [CAPACITY];
    logic signed [pl_pkg::VALUE_W-1:0] n_cells [CAPACITY];
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;
    logic [IW-1:0]                     r_rd_idx;
    logic [IW-1:0]                     r_rd_end;
    logic                              r_out_valid;
    logic [pl_pkg::STATUS_W-1:0]       r_out_status;
    logic [pl_pkg::COUNT_W-1:0]        r_out_count;
    logic signed [pl_pkg::VALUE_W-1:0] r_out_elem;
    logic                              r_out_last;

    // Decode signals
    pl_pkg::t_func    func;
    pl_pkg::t_status  req_status;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    idx_x;
    logic [XW-1:0]    rd_n_x;
    logic [XW-1:0]    rd_end_x;
    logic [XW-1:0]    n_count_x;
    logic             full;
    logic             empty;
    logic             ins_bad;
    logic             del_bad;
    logic             do_ins;
    logic             do_del;
    logic             is_read;

    assign func    = pl_pkg::t_func'(i_func);
    assign cnt_x   = XW'(r_count);
    assign pos_x   = XW'(i_pos);
    assign full    = (cnt_x == XW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
    assign del_bad = (pos_x == '0) || (pos_x > cnt_x);
    assign is_read = (func == pl_pkg::FN_READ_ALL);

    // Request decode: status, edit kind and zero-based cell index
    always_comb begin
        req_status = pl_pkg::ST_OK;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        idx_x      = '0;
        unique case (func)
            pl_pkg::FN_INS_FRONT: begin
                if (full) req_status = pl_pkg::ST_FULL;
                else      do_ins     = 1'b1;
            end
            pl_pkg::FN_INS_BACK: begin
                idx_x = cnt_x;
                if (full) req_status = pl_pkg::ST_FULL;
                else      do_ins     = 1'b1;
            end
            pl_pkg::FN_INS_POS: begin
                idx_x = pos_x - XW'(1);
                if (ins_bad)   req_status = pl_pkg::ST_BADPOS;
                else if (full) req_status = pl_pkg::ST_FULL;
                else           do_ins     = 1'b1;
            end
            pl_pkg::FN_DEL_FRONT: begin
                if (empty) req_status = pl_pkg::ST_EMPTY;
                else       do_del     = 1'b1;
            end
            pl_pkg::FN_DEL_BACK: begin
                idx_x = cnt_x - XW'(1);
                if (empty) req_status = pl_pkg::ST_EMPTY;
                else       do_del     = 1'b1;
            end
            pl_pkg::FN_DEL_POS: begin
                idx_x = pos_x - XW'(1);
                if (empty)        req_status = pl_pkg::ST_EMPTY;
                else if (del_bad) req_status = pl_pkg::ST_BADPOS;
                else              do_del     = 1'b1;
            end
            pl_pkg::FN_READ_ALL: begin
                if (empty) req_status = pl_pkg::ST_EMPTY;
            end
            default: req_status = pl_pkg::ST_OK;
        endcase
    end

    // Cell shift: insert opens a gap at idx, delete closes it
    always_comb begin
        n_cells = r_cells;
        if (do_ins) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (XW'(i) == idx_x) n_cells[i] = i_value;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (XW'(i) > idx_x) n_cells[i] = r_cells[i-1];
            end
        end
        if (do_del) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (XW'(i) >= idx_x) n_cells[i] = r_cells[i+1];
            end
        end
    end

    // Count after the request
    always_comb begin
        n_count = r_count;
        if (do_ins)      n_count = r_count + CW'(1);
        else if (do_del) n_count = r_count - CW'(1);
    end
    assign n_count_x = XW'(n_count);

    // Read-all length, capped at the response limit
    assign rd_n_x   = (cnt_x > XW'(pl_pkg::MAX_RESULTS)) ? XW'(pl_pkg::MAX_RESULTS) : cnt_x;
    assign rd_end_x = rd_n_x - XW'(1);

    // Status to controller
    assign o_sts.out_free = !r_out_valid || i_rsp_ready;
    assign o_sts.rd_multi = is_read && (cnt_x > XW'(1));
    assign o_sts.rd_last  = (r_rd_idx == r_rd_end);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_count <= n_count;
            end
            if (i_cmd.accept || i_cmd.rd_next) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Cells, read index and response word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cells      <= n_cells;
            r_rd_idx     <= IW'(1);
            r_rd_end     <= rd_end_x[IW-1:0];
            r_out_status <= req_status;
            r_out_count  <= n_count_x[pl_pkg::COUNT_W-1:0];
            r_out_elem   <= (is_read && !empty) ? r_cells[0] : '0;
            r_out_last   <= !(is_read && (cnt_x > XW'(1)));
        end else if (i_cmd.rd_next) begin
            r_rd_idx     <= r_rd_idx + IW'(1);
            r_out_status <= pl_pkg::ST_OK;
            r_out_elem   <= r_cells[r_rd_idx];
            r_out_last   <= (r_rd_idx == r_rd_end);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_element   = r_out_elem;
    assign o_last      = r_out_last;

endmodule

// ===== hdl/positional_list_engine.sv =====
// A request's first response word is loaded into the output register on acceptance.
// Each edit shifts all cells in parallel; read-all of a nonempty list gives
// min(count, 16) words from the cell row read index, one per cycle unless stalled.
// A new request is taken once the last word of the previous one is loaded.
// Reset: synchronous, active low; clears count and output valid, cells stay unknown.
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with insert/delete at front, back or
// position and an in-order read-out; controller plus datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pl_req_if.sink      i_req,
    pl_rsp_if.source    o_rsp
);

    pl_pkg::t_cmd cmd;
    pl_pkg::t_sts sts;

    // Controller
    pl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath
    pl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_req.func),
        .i_value     (i_req.value),
        .i_pos       (i_req.pos),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_count     (o_rsp.count),
        .o_element   (o_rsp.element),
        .o_last      (o_rsp.last)
    );

endmodule

// ===== hdl/pl_checker.sv =====
// ----------------------------------------------------------------------------
// pl_checker
// Port-level checks on the response channel of the list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"

module pl_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_rsp_valid,
    input logic                                i_rsp_ready,
    input logic [pl_pkg::STATUS_W-1:0]         i_rsp_status,
    input logic [pl_pkg::COUNT_W-1:0]          i_rsp_count,
    input logic signed [pl_pkg::VALUE_W-1:0]   i_rsp_element,
    input logic                                i_rsp_last
);

    // A stalled response word holds
    `PL_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_count) && $stable(i_rsp_element) && $stable(i_rsp_last), "response word changed while stalled")

    // Error responses are always single words
    `PL_ASSERT_NOW(a_err_last, i_rsp_valid && (i_rsp_status != pl_pkg::ST_OK), i_rsp_last, "error response without last")

    // A full report carries the capacity as count
    `PL_ASSERT_NOW(a_full_count, i_rsp_valid && (i_rsp_status == pl_pkg::ST_FULL), i_rsp_count == pl_pkg::COUNT_W'(CAPACITY), "full status with wrong count")

    // A nonzero element only comes with a good read-all word on a nonempty list
    `PL_ASSERT_NOW(a_elem_ok, i_rsp_valid && (i_rsp_element != '0), (i_rsp_status == pl_pkg::ST_OK) && (i_rsp_count != '0), "element on a non-read response")

endmodule

bind positional_list_engine pl_checker #(
    .CAPACITY (CAPACITY)
) u_pl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_count   (o_rsp.count),
    .i_rsp_element (o_rsp.element),
    .i_rsp_last    (o_rsp.last)
);
